>>> rtl/core/vsg_pkg.sv
package vsg_pkg;

   localparam int SAMPLE_PERIOD_NS = 100000;
   localparam int BASE_FREQ_HZ     = 50;
   localparam int LPF_GAIN_Q8      = 256;
   localparam int HPF_GAIN_Q8      = 256;

   localparam int REQ_W = 168;
   localparam int RSP_W = 160;

   typedef logic signed [63:0] word_type;
   typedef logic signed [48:0] bop_type;
   typedef logic signed [31:0] s32_type;
   typedef logic signed [18:0] s19_type;
   typedef logic signed [15:0] s16_type;
   typedef logic [30:0]        angle_type;
   typedef logic signed [32:0] cval_type;
   typedef logic signed [34:0] zval_type;

   localparam int MUL_ITER = 48;
   localparam int DIV_ITER = 64;

   localparam longint TWO_PI_Q28_L  = 64'd1686629713;
   localparam angle_type TWO_PI_Q28 = 31'(TWO_PI_Q28_L);

   localparam zval_type HALF_PI_Q30       = 35'sd1686629713;
   localparam zval_type PI_Q30            = 35'sd3373259426;
   localparam zval_type THREE_HALF_PI_Q30 = 35'sd5059889139;
   localparam zval_type TWO_PI_Q30        = 35'sd6746518852;
   localparam cval_type CORDIC_GAIN_Q30   = 33'sd652032874;

   localparam bop_type INV_SQRT3_Q16    = 49'sd37837;
   localparam bop_type VOLT_PU_Q32      = 49'sd13150598;
   localparam bop_type BASE_AMP_X64_Q16 = 49'sd171231622;
   localparam bop_type W_SCALE    = bop_type'(longint'(BASE_FREQ_HZ) * TWO_PI_Q28_L);
   localparam bop_type INC_SCALE  = bop_type'(longint'(SAMPLE_PERIOD_NS) * 64'd4194304);
   localparam bop_type SAMPLE_B   = bop_type'(SAMPLE_PERIOD_NS);
   localparam bop_type NS_PER_S   = 49'sd1000000000;
   localparam bop_type LPF_B      = bop_type'(LPF_GAIN_Q8);
   localparam bop_type HPF_B      = bop_type'(HPF_GAIN_Q8);
   localparam bop_type D625       = 49'sd625;
   localparam bop_type D625_Q16   = 49'sd40960000;

   localparam word_type ONE_PU  = 64'sd65536;
   localparam word_type P19_MIN = -64'sd262144;
   localparam word_type P19_MAX = 64'sd262143;
   localparam word_type S16_MIN = -64'sd32768;
   localparam word_type S16_MAX = 64'sd32767;
   localparam word_type U16_MAX = 64'sd65535;
   localparam word_type S32_MIN = -64'sd2147483648;
   localparam word_type S32_MAX = 64'sd2147483647;
   localparam word_type LIM24   = 64'sd16777216;

   typedef enum logic {MD_MUL, MD_DIV} md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_cmd_type;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT, ST_SEND} state_type;

   typedef enum logic [3:0] {
      CSR_DROOP, CSR_INERTIA, CSR_RKP, CSR_AKI, CSR_RKI, CSR_RV, CSR_XV, CSR_RATIO
   } csr_index_type;

   typedef enum logic [5:0] {
      SP_00, SP_01, SP_02, SP_03, SP_04, SP_05, SP_06, SP_07, SP_08, SP_09,
      SP_10, SP_11, SP_12, SP_13, SP_14, SP_15, SP_16, SP_17, SP_18, SP_19,
      SP_20, SP_21, SP_22, SP_23, SP_24, SP_25, SP_26, SP_27, SP_28, SP_29,
      SP_30, SP_31, SP_32, SP_33, SP_34, SP_35, SP_36, SP_37, SP_38, SP_39,
      SP_40, SP_41, SP_42, SP_43
   } step_type;

   function automatic word_type sat(word_type v, word_type lo, word_type hi);
      word_type r;
      r = v;
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // round half up shift
   function automatic word_type rshr(word_type v, int s);
      word_type h;
      h = word_type'(1) <<< (s - 1);
      return (v + h) >>> s;
   endfunction

   function automatic zval_type atan_q30(logic [4:0] i);
      zval_type r;
      case (i)
         5'd0:  r = 35'sh03243F6A8;
         5'd1:  r = 35'sh01DAC6705;
         5'd2:  r = 35'sh00FADBAFC;
         5'd3:  r = 35'sh007F56EA6;
         5'd4:  r = 35'sh003FEAB76;
         5'd5:  r = 35'sh001FFD55B;
         5'd6:  r = 35'sh000FFFAAA;
         5'd7:  r = 35'sh0007FFF55;
         5'd8:  r = 35'sh0003FFFEA;
         5'd9:  r = 35'sh0001FFFFD;
         5'd10: r = 35'sh0000FFFFF;
         5'd11: r = 35'sh00007FFFF;
         5'd12: r = 35'sh00003FFFF;
         5'd13: r = 35'sh00001FFFF;
         5'd14: r = 35'sh00000FFFF;
         5'd15: r = 35'sh000007FFF;
         5'd16: r = 35'sh000003FFF;
         5'd17: r = 35'sh000001FFF;
         5'd18: r = 35'sh000000FFF;
         5'd19: r = 35'sh0000007FF;
         5'd20: r = 35'sh0000003FF;
         5'd21: r = 35'sh0000001FF;
         5'd22: r = 35'sh0000000FF;
         5'd23: r = 35'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/virtual_sync_generator_ctrl.sv
// Virtual synchronous generator control: one request transaction per sample period carries
// power references, run flag, dq grid voltages, PLL frequency and three phase voltage and
// current samples; one response transaction returns measured P and Q, virtual frequency,
// phase angle with its sine and cosine, emf and the dq current references. All multiplies
// and divides run through one shared bit-serial multiply/divide unit, up to 30 multiplies
// and 12 divides per item (fewer when zero impedance or a low run flag skips steps); the
// sine/cosine CORDIC runs alongside. A new request is taken once the previous item has
// been handed to the response register. Configuration registers are written through the
// csr port, which is always ready; the user must write them only while the block is idle,
// which the block itself does not enforce.
module virtual_sync_generator_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // active_power_ref, reactive_power_ref, grid_volt_d, grid_volt_q, pll_frequency,
   // phase_volt_a, phase_volt_b, phase_volt_c, phase_amp_a, phase_amp_b, phase_amp_c
   input  logic [vsg_pkg::REQ_W-1:0]   req_tdata,
   // run_enable
   input  logic [0:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // measured_active, measured_reactive, virtual_frequency, phase_angle, angle_sine,
   // angle_cosine, emf_q, current_ref_d, current_ref_q
   output logic [vsg_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [3:0]                  csr_index,
   input  logic [23:0]                 csr_data
);

   vsg_pkg::state_type state_ff, state_in;
   vsg_pkg::step_type  step_ff, step_in;

   logic [23:0] droop_ff, inertia_ff, rkp_ff, aki_ff, rki_ff;
   logic [15:0] rv_ff, xv_ff, ratio_ff;

   logic signed [15:0] pref_ff, qref_ff;
   logic               run_ff;
   logic signed [14:0] gvd_ff, gvq_ff, va_ff, vb_ff, vc_ff;
   logic [15:0]        pll_ff;
   logic signed [13:0] ia_ff, ib_ff, ic_ff;

   vsg_pkg::word_type acc_ff, acc_in, tmp_ff, tmp_in, den_ff, den_in;
   vsg_pkg::s19_type  mp_ff, mp_in, mq_ff, mq_in, emf_ff, emf_in;
   vsg_pkg::s32_type  prefpu_ff, prefpu_in, ep_ff, ep_in, eq_ff, eq_in, wref_ff, wref_in;
   vsg_pkg::s32_type  vd_ff, vd_in, vq_ff, vq_in;
   logic [15:0]       wout_ff, wout_in;
   vsg_pkg::s16_type  idr_ff, idr_in, iqr_ff, iqr_in;
   vsg_pkg::s32_type  aint_ff, aint_in, rint_ff, rint_in;
   vsg_pkg::s32_type  lp_ff, lp_in, hp_ff, hp_in, prev_ff, prev_in;
   vsg_pkg::angle_type angle_ff, angle_in;
   logic [18:0]       phase_ff;
   logic              cs_ok_ff;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [vsg_pkg::RSP_W-1:0] rsp_tdata_ff;

   logic               accept, issue, last, load_rsp;
   vsg_pkg::md_cmd_type md_cmd;
   vsg_pkg::md_op_type md_op;
   vsg_pkg::word_type  md_a, md_res, res, hp_new, up;
   vsg_pkg::bop_type   md_b, ratio_b;
   logic               md_done, cs_done;
   vsg_pkg::s16_type   sine, cosine;
   logic [31:0]        angle_sum;

   assign accept    = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign res       = md_res;

   vsg_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (md_cmd),
      .a      (md_a),
      .b      (md_b),
      .done   (md_done),
      .result (md_res)
   );

   vsg_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .angle  (angle_ff),
      .done   (cs_done),
      .sine   (sine),
      .cosine (cosine)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vsg_pkg::ST_IDLE: if (accept) state_in = vsg_pkg::ST_EXEC;
         vsg_pkg::ST_EXEC: begin
            if (last) state_in = vsg_pkg::ST_SEND;
            else if (issue) state_in = vsg_pkg::ST_WAIT;
         end
         vsg_pkg::ST_WAIT: if (md_done) state_in = vsg_pkg::ST_EXEC;
         vsg_pkg::ST_SEND: if (!rsp_tvalid_ff || rsp_tready) state_in = vsg_pkg::ST_IDLE;
         default: state_in = vsg_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = (state_ff == vsg_pkg::ST_IDLE);
      md_cmd.start = (state_ff == vsg_pkg::ST_EXEC) && issue;
      md_cmd.op    = md_op;
      load_rsp = (state_ff == vsg_pkg::ST_SEND) && (!rsp_tvalid_ff || rsp_tready);
      if (load_rsp) rsp_tvalid_in = 1'b1;
      else if (rsp_tready) rsp_tvalid_in = 1'b0;
      else rsp_tvalid_in = rsp_tvalid_ff;
   end

   // datapath program
   always_comb begin
      ratio_b   = (ratio_ff == '0) ? vsg_pkg::bop_type'(1) : vsg_pkg::bop_type'(ratio_ff);
      hp_new    = vsg_pkg::sat(vsg_pkg::word_type'(hp_ff) + vsg_pkg::word_type'(tmp_ff)
                  - vsg_pkg::word_type'(prev_ff) - res, vsg_pkg::S32_MIN, vsg_pkg::S32_MAX);
      up        = vsg_pkg::sat(vsg_pkg::word_type'(lp_ff) + hp_new,
                  vsg_pkg::S32_MIN, vsg_pkg::S32_MAX);
      angle_sum = 32'(angle_ff) + 32'(res);
      acc_in = acc_ff;   tmp_in = tmp_ff;   den_in = den_ff;
      mp_in = mp_ff;     mq_in = mq_ff;     emf_in = emf_ff;
      prefpu_in = prefpu_ff; ep_in = ep_ff; eq_in = eq_ff; wref_in = wref_ff;
      vd_in = vd_ff;     vq_in = vq_ff;     wout_in = wout_ff;
      idr_in = idr_ff;   iqr_in = iqr_ff;
      aint_in = aint_ff; rint_in = rint_ff;
      lp_in = lp_ff;     hp_in = hp_ff;     prev_in = prev_ff;
      angle_in = angle_ff;
      md_a  = '0;
      md_b  = '0;
      md_op = vsg_pkg::MD_MUL;
      issue = 1'b0;
      last  = 1'b0;
      step_in = step_ff;
      if (state_ff == vsg_pkg::ST_EXEC) begin
         step_in = vsg_pkg::step_type'(step_ff + 6'd1);
         issue = 1'b1;
         case (step_ff)
            vsg_pkg::SP_00: begin
               md_a = vsg_pkg::word_type'(va_ff); md_b = vsg_pkg::bop_type'(ia_ff);
            end
            vsg_pkg::SP_01: begin
               acc_in = res;
               md_a = vsg_pkg::word_type'(vb_ff); md_b = vsg_pkg::bop_type'(ib_ff);
            end
            vsg_pkg::SP_02: begin
               acc_in = acc_ff + res;
               md_a = vsg_pkg::word_type'(vc_ff); md_b = vsg_pkg::bop_type'(ic_ff);
            end
            vsg_pkg::SP_03: begin
               tmp_in = acc_ff + res;
               md_a = vsg_pkg::word_type'(vb_ff) - vsg_pkg::word_type'(vc_ff);
               md_b = vsg_pkg::bop_type'(ia_ff);
            end
            vsg_pkg::SP_04: begin
               acc_in = res;
               md_a = vsg_pkg::word_type'(vc_ff) - vsg_pkg::word_type'(va_ff);
               md_b = vsg_pkg::bop_type'(ib_ff);
            end
            vsg_pkg::SP_05: begin
               acc_in = acc_ff + res;
               md_a = vsg_pkg::word_type'(va_ff) - vsg_pkg::word_type'(vb_ff);
               md_b = vsg_pkg::bop_type'(ic_ff);
            end
            vsg_pkg::SP_06: begin
               acc_in = acc_ff + res;
               md_op = vsg_pkg::MD_DIV; md_a = tmp_ff <<< 1; md_b = vsg_pkg::D625;
            end
            vsg_pkg::SP_07: begin
               mp_in = 19'(vsg_pkg::sat(res, vsg_pkg::P19_MIN, vsg_pkg::P19_MAX));
               md_a = acc_ff <<< 1; md_b = vsg_pkg::INV_SQRT3_Q16;
            end
            vsg_pkg::SP_08: begin
               md_op = vsg_pkg::MD_DIV; md_a = res; md_b = vsg_pkg::D625_Q16;
            end
            vsg_pkg::SP_09: begin
               mq_in = 19'(vsg_pkg::sat(res, vsg_pkg::P19_MIN, vsg_pkg::P19_MAX));
               md_op = vsg_pkg::MD_DIV;
               md_a = vsg_pkg::word_type'(pref_ff) <<< 11; md_b = vsg_pkg::D625;
            end
            vsg_pkg::SP_10: begin
               prefpu_in = 32'(res);
               md_op = vsg_pkg::MD_DIV;
               md_a = vsg_pkg::word_type'(qref_ff) <<< 11; md_b = vsg_pkg::D625;
            end
            vsg_pkg::SP_11: begin
               ep_in = 32'(vsg_pkg::word_type'(prefpu_ff) - vsg_pkg::word_type'(mp_ff));
               eq_in = 32'(res - vsg_pkg::word_type'(mq_ff));
               md_op = vsg_pkg::MD_DIV;
               md_a = vsg_pkg::word_type'(pll_ff) <<< 38; md_b = vsg_pkg::W_SCALE;
            end
            vsg_pkg::SP_12: begin
               wref_in = run_ff ? 32'(vsg_pkg::ONE_PU) : 32'(res);
               md_a = vsg_pkg::word_type'(ep_ff); md_b = vsg_pkg::bop_type'(droop_ff);
            end
            vsg_pkg::SP_13: begin
               md_a = vsg_pkg::rshr(res, 16) + vsg_pkg::word_type'(aint_ff);
               md_b = vsg_pkg::bop_type'(inertia_ff);
            end
            vsg_pkg::SP_14: begin
               md_a = vsg_pkg::sat(vsg_pkg::rshr(res, 16) + vsg_pkg::word_type'(wref_ff),
                                   -vsg_pkg::LIM24, vsg_pkg::LIM24);
               md_b = vsg_pkg::W_SCALE;
            end
            vsg_pkg::SP_15: begin
               wout_in = 16'(vsg_pkg::sat(vsg_pkg::rshr(res, 38), '0, vsg_pkg::U16_MAX));
               md_a = vsg_pkg::word_type'(eq_ff); md_b = vsg_pkg::bop_type'(rkp_ff);
            end
            vsg_pkg::SP_16: begin
               emf_in = 19'(vsg_pkg::sat(-(vsg_pkg::ONE_PU + vsg_pkg::rshr(res, 16)
                        + vsg_pkg::word_type'(rint_ff)), vsg_pkg::P19_MIN, vsg_pkg::P19_MAX));
               md_a = vsg_pkg::word_type'(gvd_ff); md_b = vsg_pkg::VOLT_PU_Q32;
            end
            vsg_pkg::SP_17: begin
               vd_in = 32'(vsg_pkg::rshr(res, 20));
               md_a = vsg_pkg::word_type'(gvq_ff); md_b = vsg_pkg::VOLT_PU_Q32;
            end
            vsg_pkg::SP_18: begin
               vq_in = 32'(vsg_pkg::rshr(res, 20));
               md_a = vsg_pkg::word_type'(rv_ff); md_b = vsg_pkg::bop_type'(rv_ff);
            end
            vsg_pkg::SP_19: begin
               acc_in = res;
               md_a = vsg_pkg::word_type'(xv_ff); md_b = vsg_pkg::bop_type'(xv_ff);
            end
            vsg_pkg::SP_20: begin
               den_in = acc_ff + res;
               md_a = vsg_pkg::word_type'(emf_ff); md_b = vsg_pkg::bop_type'(xv_ff);
            end
            vsg_pkg::SP_21: begin
               acc_in = -res;
               md_a = vsg_pkg::word_type'(vd_ff); md_b = vsg_pkg::bop_type'(rv_ff);
            end
            vsg_pkg::SP_22: begin
               acc_in = acc_ff + res;
               md_a = vsg_pkg::word_type'(vq_ff); md_b = vsg_pkg::bop_type'(xv_ff);
            end
            vsg_pkg::SP_23: begin
               acc_in = acc_ff + res;
               md_a = vsg_pkg::word_type'(emf_ff); md_b = vsg_pkg::bop_type'(rv_ff);
            end
            vsg_pkg::SP_24: begin
               tmp_in = -res;
               md_a = vsg_pkg::word_type'(vq_ff); md_b = vsg_pkg::bop_type'(rv_ff);
            end
            vsg_pkg::SP_25: begin
               tmp_in = tmp_ff + res;
               md_a = vsg_pkg::word_type'(vd_ff); md_b = vsg_pkg::bop_type'(xv_ff);
            end
            vsg_pkg::SP_26: begin
               tmp_in = tmp_ff - res;
               // zero impedance gives zero current references
               if (den_ff == '0) begin
                  idr_in  = '0;
                  iqr_in  = '0;
                  issue   = 1'b0;
                  step_in = vsg_pkg::SP_31;
               end else begin
                  md_op = vsg_pkg::MD_DIV; md_a = acc_ff <<< 16; md_b = 49'(den_ff);
               end
            end
            vsg_pkg::SP_27: begin
               acc_in = vsg_pkg::sat(res, -vsg_pkg::LIM24, vsg_pkg::LIM24);
               md_op = vsg_pkg::MD_DIV; md_a = tmp_ff <<< 16; md_b = 49'(den_ff);
            end
            vsg_pkg::SP_28: begin
               tmp_in = vsg_pkg::sat(res, -vsg_pkg::LIM24, vsg_pkg::LIM24);
               md_a = acc_ff; md_b = vsg_pkg::BASE_AMP_X64_Q16;
            end
            vsg_pkg::SP_29: begin
               idr_in = 16'(vsg_pkg::sat(-vsg_pkg::rshr(res, 32),
                                         vsg_pkg::S16_MIN, vsg_pkg::S16_MAX));
               md_a = tmp_ff; md_b = vsg_pkg::BASE_AMP_X64_Q16;
            end
            vsg_pkg::SP_30: begin
               iqr_in = 16'(vsg_pkg::sat(-vsg_pkg::rshr(res, 32),
                                         vsg_pkg::S16_MIN, vsg_pkg::S16_MAX));
               issue = 1'b0;
            end
            vsg_pkg::SP_31: begin
               if (run_ff) begin
                  md_a = vsg_pkg::word_type'(ep_ff); md_b = vsg_pkg::LPF_B;
               end else begin
                  aint_in = '0;
                  rint_in = '0;
                  issue   = 1'b0;
                  step_in = vsg_pkg::SP_41;
               end
            end
            vsg_pkg::SP_32: begin
               acc_in = vsg_pkg::rshr(res, 8);
               md_a = vsg_pkg::word_type'(ep_ff); md_b = vsg_pkg::HPF_B;
            end
            vsg_pkg::SP_33: begin
               tmp_in = vsg_pkg::rshr(res, 8);
               md_op = vsg_pkg::MD_DIV;
               md_a = acc_ff - vsg_pkg::word_type'(lp_ff); md_b = ratio_b;
            end
            vsg_pkg::SP_34: begin
               lp_in = 32'(vsg_pkg::sat(vsg_pkg::word_type'(lp_ff) + res,
                                        vsg_pkg::S32_MIN, vsg_pkg::S32_MAX));
               md_op = vsg_pkg::MD_DIV; md_a = vsg_pkg::word_type'(hp_ff); md_b = ratio_b;
            end
            vsg_pkg::SP_35: begin
               hp_in   = 32'(hp_new);
               prev_in = 32'(vsg_pkg::sat(tmp_ff, vsg_pkg::S32_MIN, vsg_pkg::S32_MAX));
               md_a = up; md_b = vsg_pkg::bop_type'(aki_ff);
            end
            vsg_pkg::SP_36: begin
               md_a = vsg_pkg::rshr(res, 16); md_b = vsg_pkg::SAMPLE_B;
            end
            vsg_pkg::SP_37: begin
               md_op = vsg_pkg::MD_DIV; md_a = res; md_b = vsg_pkg::NS_PER_S;
            end
            vsg_pkg::SP_38: begin
               aint_in = 32'(vsg_pkg::sat(vsg_pkg::word_type'(aint_ff) + res,
                                          vsg_pkg::S32_MIN, vsg_pkg::S32_MAX));
               md_a = vsg_pkg::word_type'(eq_ff); md_b = vsg_pkg::bop_type'(rki_ff);
            end
            vsg_pkg::SP_39: begin
               md_a = vsg_pkg::rshr(res, 16); md_b = vsg_pkg::SAMPLE_B;
            end
            vsg_pkg::SP_40: begin
               md_op = vsg_pkg::MD_DIV; md_a = res; md_b = vsg_pkg::NS_PER_S;
            end
            vsg_pkg::SP_41: begin
               if (run_ff) rint_in = 32'(vsg_pkg::sat(vsg_pkg::word_type'(rint_ff) + res,
                                                      vsg_pkg::S32_MIN, vsg_pkg::S32_MAX));
               md_a = vsg_pkg::word_type'(wout_ff); md_b = vsg_pkg::INC_SCALE;
            end
            vsg_pkg::SP_42: begin
               md_op = vsg_pkg::MD_DIV; md_a = res; md_b = vsg_pkg::NS_PER_S;
            end
            vsg_pkg::SP_43: begin
               issue = 1'b0;
               last  = 1'b1;
               if (angle_sum >= 32'(vsg_pkg::TWO_PI_Q28))
                  angle_in = 31'(angle_sum - 32'(vsg_pkg::TWO_PI_Q28));
               else
                  angle_in = 31'(angle_sum);
            end
            default: begin
               issue = 1'b0;
               last  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vsg_pkg::ST_IDLE;
         step_ff       <= vsg_pkg::SP_00;
         rsp_tvalid_ff <= 1'b0;
         cs_ok_ff      <= 1'b0;
         droop_ff      <= 24'd65536;
         inertia_ff    <= 24'd65536;
         rkp_ff        <= 24'd65536;
         aki_ff        <= 24'd65536;
         rki_ff        <= 24'd65536;
         rv_ff         <= 16'd3277;
         xv_ff         <= 16'd19661;
         ratio_ff      <= 16'd24;
         aint_ff       <= '0;
         rint_ff       <= '0;
         lp_ff         <= '0;
         hp_ff         <= '0;
         prev_ff       <= '0;
         angle_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= accept ? vsg_pkg::SP_00 : step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (accept) cs_ok_ff <= 1'b0;
         else if (cs_done) cs_ok_ff <= 1'b1;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vsg_pkg::CSR_DROOP:   droop_ff   <= csr_data;
               vsg_pkg::CSR_INERTIA: inertia_ff <= csr_data;
               vsg_pkg::CSR_RKP:     rkp_ff     <= csr_data;
               vsg_pkg::CSR_AKI:     aki_ff     <= csr_data;
               vsg_pkg::CSR_RKI:     rki_ff     <= csr_data;
               vsg_pkg::CSR_RV:      rv_ff      <= csr_data[15:0];
               vsg_pkg::CSR_XV:      xv_ff      <= csr_data[15:0];
               vsg_pkg::CSR_RATIO:   ratio_ff   <= csr_data[15:0];
               default: ;
            endcase
         end
         aint_ff  <= aint_in;
         rint_ff  <= rint_in;
         lp_ff    <= lp_in;
         hp_ff    <= hp_in;
         prev_ff  <= prev_in;
         angle_ff <= angle_in;
      end
      if (accept) begin
         pref_ff  <= req_tdata[15:0];
         qref_ff  <= req_tdata[31:16];
         gvd_ff   <= req_tdata[46:32];
         gvq_ff   <= req_tdata[61:47];
         pll_ff   <= req_tdata[77:62];
         va_ff    <= req_tdata[92:78];
         vb_ff    <= req_tdata[107:93];
         vc_ff    <= req_tdata[122:108];
         ia_ff    <= req_tdata[136:123];
         ib_ff    <= req_tdata[150:137];
         ic_ff    <= req_tdata[164:151];
         run_ff   <= req_tuser[0];
         phase_ff <= angle_ff[30:12];
      end
      acc_in_reg: begin end
      acc_ff    <= acc_in;
      tmp_ff    <= tmp_in;
      den_ff    <= den_in;
      mp_ff     <= mp_in;
      mq_ff     <= mq_in;
      emf_ff    <= emf_in;
      prefpu_ff <= prefpu_in;
      ep_ff     <= ep_in;
      eq_ff     <= eq_in;
      wref_ff   <= wref_in;
      vd_ff     <= vd_in;
      vq_ff     <= vq_in;
      wout_ff   <= wout_in;
      idr_ff    <= idr_in;
      iqr_ff    <= iqr_in;
      if (load_rsp)
         rsp_tdata_ff <= {4'b0000, iqr_ff, idr_ff, emf_ff, cosine, sine, phase_ff,
                          wout_ff, mq_ff, mp_ff};
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   a_accept_start : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == vsg_pkg::ST_EXEC && step_ff == vsg_pkg::SP_00)
      else $error("item did not start at first step");
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      angle_ff < vsg_pkg::TWO_PI_Q28) else $error("angle accumulator out of range");
   a_cordic_ready : assert property (@(posedge clock) disable iff (reset)
      state_ff == vsg_pkg::ST_SEND |-> cs_ok_ff) else $error("sine/cosine not ready");
   a_run_low_clear : assert property (@(posedge clock) disable iff (reset)
      (state_ff == vsg_pkg::ST_EXEC && step_ff == vsg_pkg::SP_31 && !run_ff)
      |=> aint_ff == '0 && rint_ff == '0) else $error("integrators not cleared");
   a_wait_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == vsg_pkg::ST_WAIT && md_done) |=> state_ff == vsg_pkg::ST_EXEC)
      else $error("unit result not consumed");
`endif

endmodule

>>> rtl/core/vsg_muldiv.sv
module vsg_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  vsg_pkg::md_cmd_type cmd,
   input  vsg_pkg::word_type   a,
   input  vsg_pkg::bop_type    b,
   output logic                done,
   output vsg_pkg::word_type   result
);

   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   vsg_pkg::md_op_type  op_ff, op_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   vsg_pkg::word_type   p_ff, p_in;
   vsg_pkg::word_type   s_ff, s_in;
   logic [47:0]         mb_ff, mb_in;
   logic [47:0]         rem_ff, rem_in;
   vsg_pkg::word_type   res_ff, res_in;

   vsg_pkg::word_type   m_sum;
   vsg_pkg::bop_type    b_mag;
   logic [48:0]         trial;
   logic                ge;

   always_comb begin
      m_sum   = a + vsg_pkg::word_type'(b >>> 1);
      b_mag   = b[48] ? -b : b;
      trial   = {rem_ff, s_ff[63]};
      ge      = (trial >= {1'b0, mb_ff});
      busy_in = busy_ff;
      fin_in  = fin_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      p_in    = p_ff;
      s_in    = s_ff;
      mb_in   = mb_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         fin_in  = 1'b0;
         p_in    = '0;
         rem_in  = '0;
         if (cmd.op == vsg_pkg::MD_MUL) begin
            cnt_in = 6'(vsg_pkg::MUL_ITER - 1);
            s_in   = b[48] ? -a : a;
            mb_in  = 48'(b_mag);
         end else begin
            cnt_in = 6'(vsg_pkg::DIV_ITER - 1);
            neg_in = m_sum[63];
            s_in   = m_sum[63] ? -m_sum : m_sum;
            mb_in  = 48'(b);
         end
      end else if (fin_ff) begin
         fin_in  = 1'b0;
         busy_in = 1'b0;
         done_in = 1'b1;
         if (op_ff == vsg_pkg::MD_MUL) res_in = p_ff;
         else if (neg_ff) res_in = -(s_ff + vsg_pkg::word_type'(rem_ff != '0));
         else res_in = s_ff;
      end else if (busy_ff) begin
         if (op_ff == vsg_pkg::MD_MUL) begin
            if (mb_ff[0]) p_in = p_ff + s_ff;
            s_in  = s_ff <<< 1;
            mb_in = mb_ff >> 1;
         end else begin
            rem_in = ge ? 48'(trial - {1'b0, mb_ff}) : 48'(trial);
            s_in   = {s_ff[62:0], ge};
         end
         if (cnt_ff == '0) fin_in = 1'b1;
         else cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      p_ff   <= p_in;
      s_ff   <= s_in;
      mb_ff  <= mb_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

`ifndef ASSERT_OFF
   a_no_restart : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("muldiv started while busy");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("muldiv done while busy");
   a_fin_done : assert property (@(posedge clock) disable iff (reset)
      (fin_ff && !cmd.start) |=> done_ff) else $error("muldiv missed done");
`endif

endmodule

>>> rtl/core/vsg_cordic.sv
module vsg_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  vsg_pkg::angle_type   angle,
   output logic                 done,
   output vsg_pkg::s16_type     sine,
   output vsg_pkg::s16_type     cosine
);

   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   vsg_pkg::cval_type  x_ff, x_in;
   vsg_pkg::cval_type  y_ff, y_in;
   vsg_pkg::zval_type  z_ff, z_in;
   vsg_pkg::s16_type   sin_ff, sin_in;
   vsg_pkg::s16_type   cos_ff, cos_in;

   vsg_pkg::zval_type  z0;
   vsg_pkg::cval_type  xs, ys;
   vsg_pkg::zval_type  at;
   vsg_pkg::word_type  xf, yf;

   always_comb begin
      z0      = vsg_pkg::zval_type'({angle, 2'b00});
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      at      = vsg_pkg::atan_q30(cnt_ff);
      xf      = neg_ff ? -vsg_pkg::word_type'(x_ff) : vsg_pkg::word_type'(x_ff);
      yf      = neg_ff ? -vsg_pkg::word_type'(y_ff) : vsg_pkg::word_type'(y_ff);
      busy_in = busy_ff;
      fin_in  = fin_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      sin_in  = sin_ff;
      cos_in  = cos_ff;
      if (start) begin
         busy_in = 1'b1;
         fin_in  = 1'b0;
         cnt_in  = '0;
         x_in    = vsg_pkg::CORDIC_GAIN_Q30;
         y_in    = '0;
         neg_in  = 1'b0;
         z_in    = z0;
         if (z0 > vsg_pkg::HALF_PI_Q30 && z0 < vsg_pkg::THREE_HALF_PI_Q30) begin
            z_in   = z0 - vsg_pkg::PI_Q30;
            neg_in = 1'b1;
         end else if (z0 >= vsg_pkg::THREE_HALF_PI_Q30) begin
            z_in = z0 - vsg_pkg::TWO_PI_Q30;
         end
      end else if (fin_ff) begin
         fin_in  = 1'b0;
         busy_in = 1'b0;
         done_in = 1'b1;
         sin_in  = 16'(vsg_pkg::sat(vsg_pkg::rshr(yf, 15), vsg_pkg::S16_MIN, vsg_pkg::S16_MAX));
         cos_in  = 16'(vsg_pkg::sat(vsg_pkg::rshr(xf, 15), vsg_pkg::S16_MIN, vsg_pkg::S16_MAX));
      end else if (busy_ff) begin
         if (!z_ff[34]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         if (cnt_ff == 5'd23) fin_in = 1'b1;
         else cnt_in = cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign done   = done_ff;
   assign sine   = sin_ff;
   assign cosine = cos_ff;

`ifndef ASSERT_OFF
   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 5'd23) else $error("cordic step out of range");
   a_done_after_fin : assert property (@(posedge clock) disable iff (reset)
      (fin_ff && !start) |=> done_ff) else $error("cordic missed done");
   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic done while busy");
`endif

endmodule

>>> bench/virtual_sync_generator_ctrl_test.sv
module virtual_sync_generator_ctrl_test;

   typedef struct {
      logic signed [15:0] p_ref;
      logic signed [15:0] q_ref;
      logic               run;
      logic signed [14:0] v_d;
      logic signed [14:0] v_q;
      logic [15:0]        pll;
      logic signed [14:0] va, vb, vc;
      logic signed [13:0] ia, ib, ic;
   } sample_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic signed [15:0] i_q;
      logic signed [15:0] i_d;
      logic signed [18:0] emf;
      logic signed [15:0] cos_v;
      logic signed [15:0] sin_v;
      logic [18:0]        angle;
      logic [15:0]        freq;
      logic signed [18:0] q_meas;
      logic signed [18:0] p_meas;
   } vsg_out_type;

   localparam longint TWO_PI_28 = 64'sd1686629713;

   class vsg_scoreboard;
      longint droop, inertia, rkp, aki, rki, rv, xv, ratio;
      longint a_int, r_int, lp, hp, prev_err;
      longint angle_acc;
      longint atan_tab[24];
      vsg_out_type expected_responses[$];
      int errors;
      int checked;

      function new();
         atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
                      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
                      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
                      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
         droop = 65536; inertia = 65536; rkp = 65536; aki = 65536; rki = 65536;
         rv = 3277; xv = 19661; ratio = 24;
         a_int = 0; r_int = 0; lp = 0; hp = 0; prev_err = 0; angle_acc = 0;
         errors = 0; checked = 0;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint clip32(longint v);
         return clip(v, -64'sd2147483648, 64'sd2147483647);
      endfunction

      function longint div_round(longint n, longint d);
         longint m;
         m = n + d / 2;
         if (m >= 0) return m / d;
         return -((-m + d - 1) / d);
      endfunction

      function longint shr_round(longint n, int s);
         return div_round(n, 64'sd1 <<< s);
      endfunction

      function void write_reg(vsg_pkg::csr_index_type idx, logic [23:0] v);
         case (idx)
            vsg_pkg::CSR_DROOP:   droop = v;
            vsg_pkg::CSR_INERTIA: inertia = v;
            vsg_pkg::CSR_RKP:     rkp = v;
            vsg_pkg::CSR_AKI:     aki = v;
            vsg_pkg::CSR_RKI:     rki = v;
            vsg_pkg::CSR_RV:      rv = v[15:0];
            vsg_pkg::CSR_XV:      xv = v[15:0];
            vsg_pkg::CSR_RATIO:   ratio = v[15:0];
            default: ;
         endcase
      endfunction

      function void sin_cos(longint acc, output longint sn, output longint cs);
         longint z, x, y, t;
         bit neg;
         z = acc * 4; x = 652032874; y = 0; neg = 0;
         if (z > 64'sd1686629713 && z < 64'sd5059889139) begin
            z -= 64'sd3373259426;
            neg = 1;
         end else if (z >= 64'sd5059889139) begin
            z -= 64'sd6746518852;
         end
         for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
               t = x - (y >>> i);
               y = y + (x >>> i);
               z -= atan_tab[i];
            end else begin
               t = x + (y >>> i);
               y = y - (x >>> i);
               z += atan_tab[i];
            end
            x = t;
         end
         if (neg) begin
            x = -x;
            y = -y;
         end
         sn = clip(shr_round(y, 15), -32768, 32767);
         cs = clip(shr_round(x, 15), -32768, 32767);
      endfunction

      function void note_sample(sample_type s);
         longint va, vb, vc, ia, ib, ic, psum, qsum, mp, mq, pref, qref, wref, ep, eq, t;
         longint wpu, wout, sn, cs, emf, vd, vq, den, nd, nq, rd, rq, idr, iqr, rt;
         longint g, h, up, inc;
         vsg_out_type e;
         va = s.va; vb = s.vb; vc = s.vc; ia = s.ia; ib = s.ib; ic = s.ic;
         rt = ratio != 0 ? ratio : 1;
         psum = va * ia + vb * ib + vc * ic;
         qsum = (vb - vc) * ia + (vc - va) * ib + (va - vb) * ic;
         mp = clip(div_round(psum * 2, 625), -262144, 262143);
         mq = clip(div_round(qsum * 2 * 37837, 625 * 65536), -262144, 262143);
         pref = div_round(longint'(s.p_ref) * 2048, 625);
         qref = div_round(longint'(s.q_ref) * 2048, 625);
         if (s.run) wref = 65536;
         else wref = div_round(longint'(s.pll) * (64'sd1 <<< 38), 50 * TWO_PI_28);
         ep = pref - mp;
         t = shr_round(ep * droop, 16) + a_int;
         t = shr_round(t * inertia, 16);
         wpu = clip(t + wref, -(64'sd1 <<< 24), 64'sd1 <<< 24);
         wout = clip(div_round(wpu * 50 * TWO_PI_28, 64'sd1 <<< 38), 0, 65535);
         e.angle = 19'(angle_acc >>> 12);
         sin_cos(angle_acc, sn, cs);
         eq = qref - mq;
         emf = clip(-(65536 + shr_round(eq * rkp, 16) + r_int), -262144, 262143);
         vd = shr_round(longint'(s.v_d) * 13150598, 20);
         vq = shr_round(longint'(s.v_q) * 13150598, 20);
         den = rv * rv + xv * xv;
         idr = 0; iqr = 0;
         if (den != 0) begin
            nd = -(xv * emf) + rv * vd + xv * vq;
            nq = -(rv * emf) + rv * vq - xv * vd;
            rd = clip(div_round(nd * 65536, den), -(64'sd1 <<< 24), 64'sd1 <<< 24);
            rq = clip(div_round(nq * 65536, den), -(64'sd1 <<< 24), 64'sd1 <<< 24);
            idr = clip(-shr_round(rd * 171231622, 32), -32768, 32767);
            iqr = clip(-shr_round(rq * 171231622, 32), -32768, 32767);
         end
         if (s.run) begin
            g = shr_round(ep * vsg_pkg::LPF_GAIN_Q8, 8);
            h = shr_round(ep * vsg_pkg::HPF_GAIN_Q8, 8);
            lp = clip32(lp + div_round(g - lp, rt));
            hp = clip32(hp + (h - prev_err) - div_round(hp, rt));
            prev_err = clip32(h);
            up = clip32(lp + hp);
            a_int = clip32(a_int + div_round(shr_round(up * aki, 16)
                                             * vsg_pkg::SAMPLE_PERIOD_NS, 1000000000));
            r_int = clip32(r_int + div_round(shr_round(eq * rki, 16)
                                             * vsg_pkg::SAMPLE_PERIOD_NS, 1000000000));
         end else begin
            a_int = 0;
            r_int = 0;
         end
         inc = (wout * vsg_pkg::SAMPLE_PERIOD_NS * 4194304 + 500000000) / 1000000000;
         angle_acc = (angle_acc + inc) % TWO_PI_28;
         e.pad = '0;
         e.p_meas = 19'(mp); e.q_meas = 19'(mq); e.freq = 16'(wout);
         e.sin_v = 16'(sn); e.cos_v = 16'(cs); e.emf = 19'(emf);
         e.i_d = 16'(idr); e.i_q = 16'(iqr);
         expected_responses.push_back(e);
      endfunction

      function void compare(string name, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
         end
      endfunction

      function void check_response(vsg_out_type a);
         vsg_out_type e;
         if (expected_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, a);
            return;
         end
         e = expected_responses.pop_front();
         checked++;
         compare("measured_active", e.p_meas, a.p_meas);
         compare("measured_reactive", e.q_meas, a.q_meas);
         compare("virtual_frequency", e.freq, a.freq);
         compare("phase_angle", e.angle, a.angle);
         compare("angle_sine", e.sin_v, a.sin_v);
         compare("angle_cosine", e.cos_v, a.cos_v);
         compare("emf_q", e.emf, a.emf);
         compare("current_ref_d", e.i_d, a.i_d);
         compare("current_ref_q", e.i_q, a.i_q);
      endfunction
   endclass

   logic                        clock = 0;
   logic                        reset = 1;
   logic                        req_tvalid = 0;
   logic                        req_tready;
   logic [vsg_pkg::REQ_W-1:0]   req_tdata = '0;
   logic [0:0]                  req_tuser = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 0;
   logic [vsg_pkg::RSP_W-1:0]   rsp_tdata;
   logic                        csr_valid = 0;
   logic                        csr_ready;
   logic [3:0]                  csr_index = '0;
   logic [23:0]                 csr_data = '0;

   vsg_scoreboard sb = new();
   int  idle_mode = 0;
   int  sent = 0;
   longint cycles = 0;

   virtual_sync_generator_ctrl u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd30000000) begin
         $display("virtual_sync_generator_ctrl_test NOT OK");
         $finish;
      end
   end

   // response side: check then decide on stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(vsg_out_type'(rsp_tdata));
      if (idle_mode == 2) rsp_tready <= $urandom_range(0, 99) >= 68;
      else if (idle_mode == 3) rsp_tready <= $urandom_range(0, 99) >= 14;
      else rsp_tready <= 1;
   end

   task automatic send(sample_type s);
      while ((idle_mode == 1 && $urandom_range(0, 99) < 68) ||
             (idle_mode == 3 && $urandom_range(0, 99) < 14)) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= s.run;
      req_tdata  <= {3'b0, s.ic, s.ib, s.ia, s.vc, s.vb, s.va, s.pll, s.v_q, s.v_d,
                     s.q_ref, s.p_ref};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(s);
      sent++;
   endtask

   task automatic write_reg(vsg_pkg::csr_index_type idx, logic [23:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic sample_type any_sample();
      sample_type s;
      s.p_ref = 16'($urandom); s.q_ref = 16'($urandom); s.run = 1'($urandom);
      s.v_d = 15'($urandom); s.v_q = 15'($urandom); s.pll = 16'($urandom);
      s.va = 15'($urandom); s.vb = 15'($urandom); s.vc = 15'($urandom);
      s.ia = 14'($urandom); s.ib = 14'($urandom); s.ic = 14'($urandom);
      return s;
   endfunction

   // plausible operating point with random content, mostly running
   function automatic sample_type operating_sample();
      sample_type s;
      int amp_v, amp_i;
      amp_v = $urandom_range(0, 6000);
      amp_i = $urandom_range(0, 3000);
      s.p_ref = 16'($urandom_range(0, 20000) - 10000);
      s.q_ref = 16'($urandom_range(0, 20000) - 10000);
      s.run = $urandom_range(0, 99) < 90;
      s.v_d = 15'($urandom_range(0, 2 * amp_v) - amp_v);
      s.v_q = 15'($urandom_range(0, 1000) - 500);
      s.pll = 16'($urandom_range(19000, 21200));
      s.va = 15'($urandom_range(0, 2 * amp_v) - amp_v);
      s.vb = 15'($urandom_range(0, 2 * amp_v) - amp_v);
      s.vc = -(s.va + s.vb);
      s.ia = 14'($urandom_range(0, 2 * amp_i) - amp_i);
      s.ib = 14'($urandom_range(0, 2 * amp_i) - amp_i);
      s.ic = 14'($urandom_range(0, 2 * amp_i) - amp_i);
      return s;
   endfunction

   task automatic write_all(logic [23:0] d, logic [23:0] j, logic [23:0] kp, logic [23:0] ka,
                            logic [23:0] kr, logic [15:0] r, logic [15:0] x, logic [15:0] f);
      write_reg(vsg_pkg::CSR_DROOP, d);
      write_reg(vsg_pkg::CSR_INERTIA, j);
      write_reg(vsg_pkg::CSR_RKP, kp);
      write_reg(vsg_pkg::CSR_AKI, ka);
      write_reg(vsg_pkg::CSR_RKI, kr);
      write_reg(vsg_pkg::CSR_RV, {8'd0, r});
      write_reg(vsg_pkg::CSR_XV, {8'd0, x});
      write_reg(vsg_pkg::CSR_RATIO, {8'd0, f});
      csr_valid <= 0;
   endtask

   initial begin
      sample_type s;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, run both ways, pll extremes
      for (int k = 0; k < 16; k++) begin
         s.run = k[0];
         s.p_ref = k[1] ? 16'sh7fff : 16'sh8000;
         s.q_ref = k[2] ? 16'sh8000 : 16'sh7fff;
         s.pll = k[3] ? 16'hffff : 16'h0000;
         s.v_d = k[1] ? 15'sh3fff : 15'sh4000;
         s.v_q = k[2] ? 15'sh3fff : 15'sh4000;
         s.va = k[2] ? 15'sh3fff : 15'sh4000;
         s.vb = k[3] ? 15'sh3fff : 15'sh4000;
         s.vc = k[1] ? 15'sh4000 : 15'sh3fff;
         s.ia = k[1] ? 14'sh1fff : 14'sh2000;
         s.ib = k[3] ? 14'sh2000 : 14'sh1fff;
         s.ic = k[2] ? 14'sh1fff : 14'sh2000;
         if (k == 0) begin
            s = '{16'sd0, 16'sd0, 1'b0, 15'sd0, 15'sd0, 16'd20106, 15'sd0, 15'sd0, 15'sd0,
                  14'sd0, 14'sd0, 14'sd0};
         end
         send(s);
      end
      for (int k = 0; k < 6; k++) send(operating_sample());
      drain();

      // zero impedance and zero filter ratio
      write_all(24'd65536, 24'd65536, 24'd65536, 24'd65536, 24'd65536, 16'd0, 16'd0, 16'd0);
      for (int k = 0; k < 4; k++) send(k < 2 ? operating_sample() : any_sample());
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         idle_mode = ph % 4;
         case (ph)
            0: write_all('1, '1, '1, '1, '1, '1, '1, '1);
            1: write_all('0, '0, '0, '0, '0, '0, 16'd1, 16'd1);
            2: write_all(24'd65536, 24'd65536, 24'd65536, 24'd65536, 24'd65536,
                         16'd3277, 16'd19661, 16'd24);
            default: write_all(24'($urandom_range(0, 24'h0fffff)),
                               24'($urandom_range(0, 24'h0fffff)), 24'($urandom),
                               24'($urandom_range(0, 24'h3fffff)), 24'($urandom),
                               16'($urandom), 16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 100)));
         endcase
         for (int k = 0; k < 78; k++) begin
            if ($urandom_range(0, 99) < 75) send(operating_sample());
            else send(any_sample());
         end
         drain();
      end

      $display("covered %0d samples and %0d checked responses across register sets",
               sent, sb.checked);
      $display("including extremes, zero impedance, run toggling and all stall modes");
      if (sb.errors == 0 && sb.expected_responses.size() == 0)
         $display("virtual_sync_generator_ctrl_test OK");
      else
         $display("virtual_sync_generator_ctrl_test NOT OK");
      $finish;
   end
endmodule
